@@ design/sjis_to_font_rom_address_unit_macros.svh @@
// Assertion macros shared by the Shift-JIS to font ROM address unit.
`ifndef SJIS_TO_FONT_ROM_ADDRESS_UNIT_MACROS_SVH
`define SJIS_TO_FONT_ROM_ADDRESS_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SJTF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define SJTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sjtf_pkg.sv @@
// Types and constants of the Shift-JIS to font ROM address unit.
package sjtf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 18;

  localparam logic [AddrW-1:0] AsciiBase = 18'd255968;
  localparam logic [15:0]      SubstCode = 16'h828F;

  // Ku range bases, given as JIS row bytes (ku + 0x20) and ROM offsets.
  localparam logic [ByteW-1:0] Row1Lo  = 8'h21;  // ku 1
  localparam logic [ByteW-1:0] Row1Hi  = 8'h2F;  // ku 15
  localparam logic [ByteW-1:0] Row16Lo = 8'h30;  // ku 16
  localparam logic [ByteW-1:0] Row16Hi = 8'h4F;  // ku 47
  localparam logic [ByteW-1:0] Row48Lo = 8'h50;  // ku 48
  localparam logic [ByteW-1:0] Row48Hi = 8'h74;  // ku 84
  localparam logic [ByteW-1:0] Row85   = 8'h75;  // ku 85
  localparam logic [ByteW-1:0] Row88Lo = 8'h78;  // ku 88
  localparam logic [ByteW-1:0] Row88Hi = 8'h79;  // ku 89
  localparam logic [ByteW-1:0] CellLo  = 8'h21;  // ten 1
  localparam logic [ByteW-1:0] CellHi  = 8'h7E;  // ten 94

  localparam logic [AddrW-1:0] Base1  = 18'd0;
  localparam logic [AddrW-1:0] Base16 = 18'd43584;
  localparam logic [AddrW-1:0] Base48 = 18'd138464;
  localparam logic [AddrW-1:0] Base85 = 18'd246944;
  localparam logic [AddrW-1:0] Base88 = 18'd249952;

  localparam logic [6:0] CellsPerRow = 7'd94;

  // Result of the two-byte address calculation.
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             hit;
  } pair_res_t;

  // A byte that stands for a character on its own.
  function automatic logic is_single(input logic [ByteW-1:0] b);
    return (b < 8'h80) || ((b >= 8'hA1) && (b <= 8'hDF));
  endfunction

endpackage

@@ design/sjtf_pair_addr.sv @@
// Two-byte Shift-JIS code to JIS X 0208 ku/ten to 32-byte glyph address.
module sjtf_pair_addr (
  input  logic [sjtf_pkg::ByteW-1:0] lead_i,
  input  logic [sjtf_pkg::ByteW-1:0] trail_i,
  output sjtf_pkg::pair_res_t        res_o
);

  logic [7:0]                  c1_adj;
  logic [7:0]                  c2_adj;
  logic [7:0]                  c1_dbl;
  logic [7:0]                  jis_hi;
  logic [7:0]                  jis_lo;
  logic [7:0]                  row_base;
  logic [5:0]                  row_off;
  logic [6:0]                  cell_off;
  logic [11:0]                 glyph_idx;
  logic [sjtf_pkg::AddrW-1:0]  rom_base;
  logic                        row_hit;
  logic                        cell_hit;

  // Shift-JIS to JIS X 0208, all arithmetic wraps at eight bits.
  always_comb begin
    c1_adj = (lead_i >= 8'hE0) ? lead_i - 8'h40 : lead_i;
    c2_adj = (trail_i >= 8'h80) ? trail_i - 8'h01 : trail_i;
    c1_dbl = {c1_adj[6:0] - 7'h70, 1'b0};
    if (c2_adj >= 8'h9E) begin
      jis_hi = c1_dbl;
      jis_lo = c2_adj - 8'h7D;
    end else begin
      jis_hi = c1_dbl - 8'h01;
      jis_lo = c2_adj - 8'h1F;
    end
  end

  // Ku range selection; a ku that wraps below zero lands above every range.
  always_comb begin
    row_hit  = 1'b1;
    row_base = sjtf_pkg::Row1Lo;
    rom_base = sjtf_pkg::Base1;
    priority if (jis_hi >= sjtf_pkg::Row1Lo && jis_hi <= sjtf_pkg::Row1Hi) begin
      row_base = sjtf_pkg::Row1Lo;
      rom_base = sjtf_pkg::Base1;
    end else if (jis_hi >= sjtf_pkg::Row16Lo && jis_hi <= sjtf_pkg::Row16Hi) begin
      row_base = sjtf_pkg::Row16Lo;
      rom_base = sjtf_pkg::Base16;
    end else if (jis_hi >= sjtf_pkg::Row48Lo && jis_hi <= sjtf_pkg::Row48Hi) begin
      row_base = sjtf_pkg::Row48Lo;
      rom_base = sjtf_pkg::Base48;
    end else if (jis_hi == sjtf_pkg::Row85) begin
      row_base = sjtf_pkg::Row85;
      rom_base = sjtf_pkg::Base85;
    end else if (jis_hi >= sjtf_pkg::Row88Lo && jis_hi <= sjtf_pkg::Row88Hi) begin
      row_base = sjtf_pkg::Row88Lo;
      rom_base = sjtf_pkg::Base88;
    end else begin
      row_hit = 1'b0;
    end
  end

  always_comb begin
    logic [7:0] row_diff;
    logic [7:0] cell_diff;
    row_diff   = jis_hi - row_base;
    cell_diff  = jis_lo - sjtf_pkg::CellLo;
    row_off    = row_diff[5:0];
    cell_off   = cell_diff[6:0];
    cell_hit   = (jis_lo >= sjtf_pkg::CellLo) && (jis_lo <= sjtf_pkg::CellHi);
    glyph_idx  = {6'd0, row_off} * {5'd0, sjtf_pkg::CellsPerRow} + {5'd0, cell_off};
    res_o.hit  = row_hit && cell_hit;
    res_o.addr = res_o.hit ? {1'b0, glyph_idx, 5'd0} + rom_base : '0;
  end

endmodule

@@ design/sjis_to_font_rom_address_unit.sv @@
// Top level of the Shift-JIS to font ROM address unit.
//
//  Channel  Dir  Handshake                    Contents
//  s_axis   in   s_axis_tvalid/s_axis_tready  one Shift-JIS byte per transaction
//  m_axis   out  m_axis_tvalid/m_axis_tready  glyph address and flags per character
//
// The unit accepts one byte per cycle when the output side keeps up. A lead
// byte is only stored and causes no output transaction; a single byte or a
// trail byte is captured in the input register and moves on to the result
// register, which drives m_axis_tvalid. The conversion between them is a
// single pass of compares, a multiply by 94 and a few adds.
// Reset clears the held lead byte and both valid flags. When the result
// register is full and m_axis_tready is low, it holds, the input register still
// fills once, and s_axis_tready drops only while both are full.
module sjis_to_font_rom_address_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] sjis_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [17:0] glyph_address, [23:18] zero
  output logic [2:0]  m_axis_tuser    // [0] full_width, [1] mapped, [2] use_substitute
);

  // Lead byte tracking.
  logic                        lead_pending_q, lead_pending_d;
  logic [sjtf_pkg::ByteW-1:0]  lead_byte_q, lead_byte_d;

  // Input register: one character ready for conversion.
  logic                        in_valid_q, in_valid_d;
  logic                        in_full_q;
  logic [sjtf_pkg::ByteW-1:0]  in_lead_q;
  logic [sjtf_pkg::ByteW-1:0]  in_byte_q;

  // Result register.
  logic                        out_valid_q, out_valid_d;
  logic [sjtf_pkg::AddrW-1:0]  out_addr_q, out_addr_d;
  logic                        out_full_q;
  logic                        out_mapped_q, out_mapped_d;
  logic                        out_subst_q, out_subst_d;

  logic                        in_accept;
  logic                        in_is_single;
  logic                        takes_char;
  logic                        out_free;
  logic                        in_advance;
  sjtf_pkg::pair_res_t         pair_res;

  assign in_accept    = s_axis_tvalid && s_axis_tready;
  assign in_is_single = sjtf_pkg::is_single(s_axis_tdata);
  // A byte becomes a character when it completes a pair or stands alone.
  assign takes_char   = lead_pending_q || in_is_single;
  assign out_free     = !out_valid_q || m_axis_tready;
  assign in_advance   = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_comb begin
    lead_pending_d = lead_pending_q;
    lead_byte_d    = lead_byte_q;
    if (in_accept) begin
      lead_pending_d = !takes_char;
      if (!takes_char) begin
        lead_byte_d = s_axis_tdata;
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept && takes_char) begin
      in_valid_d = 1'b1;
    end else if (in_advance) begin
      in_valid_d = 1'b0;
    end
  end

  sjtf_pair_addr u_pair_addr (
    .lead_i  (in_lead_q),
    .trail_i (in_byte_q),
    .res_o   (pair_res)
  );

  // Single bytes map only for bytes 0x20 to 0x7F, 16 bytes per glyph.
  always_comb begin
    logic [6:0] ascii_off;
    ascii_off = 7'(in_byte_q - 8'h20);
    if (in_full_q) begin
      out_addr_d   = pair_res.addr;
      out_mapped_d = pair_res.hit;
      out_subst_d  = ({in_lead_q, in_byte_q} == sjtf_pkg::SubstCode);
    end else begin
      out_mapped_d = (in_byte_q >= 8'h20) && (in_byte_q <= 8'h7F);
      out_addr_d   = out_mapped_d ? sjtf_pkg::AsciiBase + {7'd0, ascii_off, 4'd0} : '0;
      out_subst_d  = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q <= 1'b0;
      lead_byte_q    <= '0;
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      lead_pending_q <= lead_pending_d;
      lead_byte_q    <= lead_byte_d;
      in_valid_q     <= in_valid_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept && takes_char) begin
      in_full_q <= lead_pending_q;
      in_lead_q <= lead_byte_q;
      in_byte_q <= s_axis_tdata;
    end
    if (in_advance) begin
      out_addr_q   <= out_addr_d;
      out_full_q   <= in_full_q;
      out_mapped_q <= out_mapped_d;
      out_subst_q  <= out_subst_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_addr_q};
  assign m_axis_tuser  = {out_subst_q, out_mapped_q, out_full_q};

  `include "sjis_to_font_rom_address_unit_macros.svh"

  // An unmapped character always points at address zero.
  `SJTF_ASSERT_NOW(a_unmapped_zero, out_valid_q && !out_mapped_q, out_addr_q == '0, "unmapped result has nonzero address")
  // Only a two-byte code can ask for the substitute glyph.
  `SJTF_ASSERT_NOW(a_subst_full, out_valid_q && out_subst_q, out_full_q, "substitute flag on a single-byte result")
  // Mapped single bytes land in the ASCII area of the ROM.
  `SJTF_ASSERT_NOW(a_ascii_area, out_valid_q && !out_full_q && out_mapped_q, out_addr_q >= sjtf_pkg::AsciiBase, "single-byte address below ASCII area")
  // A stored lead byte is waiting for its trail and queues nothing.
  `SJTF_ASSERT_NEXT(a_lead_held, in_accept && !takes_char && !in_advance, lead_pending_q && (in_valid_q == $past(in_valid_q)), "lead byte handling broke")

endmodule
